[rtl/affine_transform_compose_unit_assert.svh]
// Assertion macros used by the checker file acu_checker.
`ifndef AFFINE_TRANSFORM_COMPOSE_UNIT_ASSERT_SVH
`define AFFINE_TRANSFORM_COMPOSE_UNIT_ASSERT_SVH

// Antecedent implies consequent, sampled on clk, off while rst is high.
`define ACU_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("acu check failed");

// Expression never true outside reset.
`define ACU_ASSERT_NEVER(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("acu check failed");

`endif

[rtl/acu_pkg.sv]
`timescale 1ns / 1ps
package acu_pkg;

  localparam int CordicStagesDefault = 16;
  localparam int CordicStagesMax     = 24;
  localparam int AngleStages         = 7;
  localparam int MatrixStages        = 4;

  localparam logic [24:0] Deg180Q16 = 25'd11796480;
  localparam logic [23:0] Deg90Q16  = 24'd5898240;
  localparam logic [30:0] PiQ29     = 31'd1686629713;
  localparam logic [36:0] RadRound  = 37'd2949120;
  // ceil(2^29 / 45): exact floor division by 45 for values below 2^25
  localparam logic [23:0] Recip45   = 24'd11930465;
  localparam logic signed [33:0] KQ30 = 34'sd652032874;

  typedef struct packed {
    logic signed [31:0] ox;
    logic signed [31:0] oy;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] sx;
    logic signed [31:0] sy;
  } payload_t;

  typedef struct packed {
    logic neg_both;
    logic neg_cos;
  } fold_t;

  function automatic int cap_stages(int n);
    return (n > CordicStagesMax) ? CordicStagesMax : n;
  endfunction

  function automatic int latency(int n);
    return AngleStages + cap_stages(n) + 1 + MatrixStages;
  endfunction

  function automatic logic signed [33:0] atan_q30(int idx);
    logic signed [33:0] v;
    case (idx)
      0:  v = 34'sd843314856;
      1:  v = 34'sd497837829;
      2:  v = 34'sd263043836;
      3:  v = 34'sd133525158;
      4:  v = 34'sd67021686;
      5:  v = 34'sd33543515;
      6:  v = 34'sd16775850;
      7:  v = 34'sd8388437;
      8:  v = 34'sd4194282;
      9:  v = 34'sd2097149;
      10: v = 34'sd1048575;
      11: v = 34'sd524287;
      12: v = 34'sd262143;
      13: v = 34'sd131071;
      14: v = 34'sd65535;
      15: v = 34'sd32767;
      16: v = 34'sd16383;
      17: v = 34'sd8191;
      18: v = 34'sd4095;
      19: v = 34'sd2047;
      20: v = 34'sd1023;
      21: v = 34'sd511;
      22: v = 34'sd255;
      default: v = 34'sd127;
    endcase
    return v;
  endfunction

  // Round a Q16.16 x Q2.30 product back to Q16.16 and clamp.
  function automatic logic signed [31:0] round_q30(logic signed [65:0] p);
    logic signed [65:0] t;
    t = (p + 66'sd536870912) >>> 30;
    if (t > 66'sd2147483647) return 32'sh7fffffff;
    if (t < -66'sd2147483648) return 32'sh80000000;
    return t[31:0];
  endfunction

  // Position minus two rounded Q32 products, clamped.
  function automatic logic signed [31:0] trans(logic signed [31:0] pos,
                                               logic signed [63:0] p1,
                                               logic signed [63:0] p2);
    logic signed [47:0] r1;
    logic signed [47:0] r2;
    logic signed [49:0] s;
    r1 = 48'((p1 + 64'sd32768) >>> 16);
    r2 = 48'((p2 + 64'sd32768) >>> 16);
    s  = 50'(pos) - 50'(r1) - 50'(r2);
    if (s > 50'sd2147483647) return 32'sh7fffffff;
    if (s < -50'sd2147483648) return 32'sh80000000;
    return s[31:0];
  endfunction

endpackage

[rtl/acu_angle.sv]
`timescale 1ns / 1ps
module acu_angle (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic signed [31:0]      angle_deg,
  input  acu_pkg::payload_t       in_pay,
  output logic                    out_valid,
  output logic signed [33:0]      out_z,
  output acu_pkg::fold_t          out_fold,
  output acu_pkg::payload_t       out_pay
);

  // stage registers
  logic               v1, v2, v3, v4, v5, v6, v7;
  acu_pkg::payload_t  p1, p2, p3, p4, p5, p6, p7;
  acu_pkg::fold_t     f2, f3, f4, f5, f6, f7;
  logic [24:0]        r1;
  logic [22:0]        r2, r3;
  logic [46:0]        prod3;
  logic [17:0]        qq4;
  logic [5:0]         rr4;
  logic [48:0]        a5;
  logic [36:0]        n5;
  logic [31:0]        ah6;
  logic [20:0]        m6;
  logic [33:0]        z7;

  // reduce modulo 360 deg: 360*2^16 = 45*2^19, so reduce the top bits mod 45
  logic signed [12:0] h;
  logic [13:0]        u;
  logic [24:0]        up;
  logic [7:0]         q;
  logic [13:0]        rem0;
  logic [5:0]         rem;
  always_comb begin
    h    = angle_deg[31:19];
    u    = 14'($signed({h[12], h}) + 14'sd4140);
    up   = 25'(u) * 25'd1456;
    q    = up[23:16];
    rem0 = u - 14'(q * 8'd45);
    rem  = (rem0 >= 14'd45) ? 6'(rem0 - 14'd45) : rem0[5:0];
  end

  // fold into [0, 90] deg
  logic [23:0] fa;
  logic        nb, nc;
  logic [22:0] fr;
  always_comb begin
    nb = (r1 >= acu_pkg::Deg180Q16);
    fa = nb ? 24'(r1 - acu_pkg::Deg180Q16) : r1[23:0];
    nc = (fa > acu_pkg::Deg90Q16);
    fr = nc ? 23'(acu_pkg::Deg180Q16[23:0] - fa) : fa[22:0];
  end

  logic [37:0] y6;
  logic [44:0] q2p;
  always_comb begin
    y6  = 38'(a5[16:0]) * 38'd45 + 38'(n5);
    q2p = 45'(m6) * 45'(acu_pkg::Recip45);
  end

  // advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      {v1, v2, v3, v4, v5, v6, v7} <= '0;
    end else begin
      {v1, v2, v3, v4, v5, v6, v7} <= {in_valid, v1, v2, v3, v4, v5, v6};
    end
  end

  // advance data
  always_ff @(posedge clk) begin
    r1 <= {rem, angle_deg[18:0]};
    p1 <= in_pay;

    r2 <= fr;
    f2 <= '{neg_both: nb, neg_cos: nc};
    p2 <= p1;

    prod3 <= 47'(r2) * 47'(acu_pkg::Recip45);
    r3    <= r2;
    f3    <= f2;
    p3    <= p2;

    qq4 <= prod3[46:29];
    rr4 <= 6'(r3 - 23'(prod3[46:29] * 18'd45));
    f4  <= f3;
    p4  <= p3;

    a5 <= 49'(qq4) * 49'(acu_pkg::PiQ29);
    n5 <= 37'(rr4) * 37'(acu_pkg::PiQ29) + acu_pkg::RadRound;
    f5 <= f4;
    p5 <= p4;

    ah6 <= a5[48:17];
    m6  <= y6[37:17];
    f6  <= f5;
    p6  <= p5;

    z7 <= 34'(ah6) + 34'(q2p[44:29]);
    f7 <= f6;
    p7 <= p6;
  end

  assign out_valid = v7;
  assign out_z     = $signed(z7);
  assign out_fold  = f7;
  assign out_pay   = p7;

endmodule

[rtl/acu_cordic.sv]
`timescale 1ns / 1ps
module acu_cordic #(
  parameter int CORDIC_STAGES = acu_pkg::CordicStagesDefault
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic signed [33:0]      in_z,
  input  acu_pkg::fold_t          in_fold,
  input  acu_pkg::payload_t       in_pay,
  output logic                    out_valid,
  output logic signed [33:0]      out_cos,
  output logic signed [33:0]      out_sin,
  output acu_pkg::payload_t       out_pay
);

  localparam int N = acu_pkg::cap_stages(CORDIC_STAGES);

  logic                    vld  [0:N];
  logic signed [33:0]      xs   [0:N];
  logic signed [33:0]      ys   [0:N];
  logic signed [33:0]      zs   [0:N];
  acu_pkg::fold_t          fl   [0:N];
  acu_pkg::payload_t       pl   [0:N];

  assign vld[0] = in_valid;
  assign xs[0]  = acu_pkg::KQ30;
  assign ys[0]  = '0;
  assign zs[0]  = in_z;
  assign fl[0]  = in_fold;
  assign pl[0]  = in_pay;

  // one rotation step per register stage
  for (genvar i = 0; i < N; i++) begin : g_step
    localparam logic signed [33:0] Atan = acu_pkg::atan_q30(i);
    logic signed [33:0] xsh, ysh;
    assign xsh = xs[i] >>> i;
    assign ysh = ys[i] >>> i;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (!zs[i][33]) begin
        xs[i+1] <= xs[i] - ysh;
        ys[i+1] <= ys[i] + xsh;
        zs[i+1] <= zs[i] - Atan;
      end else begin
        xs[i+1] <= xs[i] + ysh;
        ys[i+1] <= ys[i] - xsh;
        zs[i+1] <= zs[i] + Atan;
      end
      fl[i+1] <= fl[i];
      pl[i+1] <= pl[i];
    end
  end

  // unfold quadrant; sine is of the negated angle
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vld[N];
    end
  end

  always_ff @(posedge clk) begin
    out_cos <= (fl[N].neg_cos != fl[N].neg_both) ? -xs[N] : xs[N];
    out_sin <= fl[N].neg_both ? ys[N] : -ys[N];
    out_pay <= pl[N];
  end

endmodule

[rtl/acu_matrix.sv]
`timescale 1ns / 1ps
module acu_matrix (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic signed [33:0]      in_cos,
  input  logic signed [33:0]      in_sin,
  input  acu_pkg::payload_t       in_pay,
  output logic                    out_valid,
  output logic signed [31:0]      m_a,
  output logic signed [31:0]      m_b,
  output logic signed [31:0]      m_tx,
  output logic signed [31:0]      m_c,
  output logic signed [31:0]      m_d,
  output logic signed [31:0]      m_ty
);

  logic                    v1, v2, v3;
  acu_pkg::payload_t       p1, p2, p3;
  logic signed [65:0]      pa, pb, pc, pd;
  logic signed [31:0]      a2, b2, c2, d2;
  logic signed [31:0]      a3, b3, c3, d3;
  logic signed [63:0]      q1, q2, q3, q4;
  logic signed [33:0]      nsin;

  assign nsin = -in_sin;

  always_ff @(posedge clk) begin
    if (rst) begin
      {v1, v2, v3, out_valid} <= '0;
    end else begin
      {v1, v2, v3, out_valid} <= {in_valid, v1, v2, v3};
    end
  end

  always_ff @(posedge clk) begin
    // scale times trig
    pa <= 66'(in_pay.sx) * 66'(in_cos);
    pb <= 66'(in_pay.sy) * 66'(in_sin);
    pc <= 66'(in_pay.sx) * 66'(nsin);
    pd <= 66'(in_pay.sy) * 66'(in_cos);
    p1 <= in_pay;

    // round linear entries
    a2 <= acu_pkg::round_q30(pa);
    b2 <= acu_pkg::round_q30(pb);
    c2 <= acu_pkg::round_q30(pc);
    d2 <= acu_pkg::round_q30(pd);
    p2 <= p1;

    // origin times entries
    q1 <= 64'(p2.ox) * 64'(a2);
    q2 <= 64'(p2.oy) * 64'(b2);
    q3 <= 64'(p2.ox) * 64'(c2);
    q4 <= 64'(p2.oy) * 64'(d2);
    {a3, b3, c3, d3} <= {a2, b2, c2, d2};
    p3 <= p2;

    // translations and output word
    m_a  <= a3;
    m_b  <= b3;
    m_c  <= c3;
    m_d  <= d3;
    m_tx <= acu_pkg::trans(p3.px, q1, q2);
    m_ty <= acu_pkg::trans(p3.py, q3, q4);
  end

endmodule

[rtl/affine_transform_compose_unit.sv]
`timescale 1ns / 1ps
// Builds the six entries of a 2D affine matrix (Q16.16) from origin, position,
// angle in degrees and scale. A word may be started in every cycle; busy is
// never raised. Each word's result appears on the m_* ports with done high
// for one cycle (CORDIC stages capped at 24), after the angle reduction and
// degrees-to-radians divide stages, the CORDIC rotation stages plus a quadrant
// fix, and the multiply and rounding stages. The receiver cannot stall; it
// must take each result when done is high.
module affine_transform_compose_unit #(
  parameter int CORDIC_STAGES = acu_pkg::CordicStagesDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] origin_x,
  input  logic signed [31:0] origin_y,
  input  logic signed [31:0] position_x,
  input  logic signed [31:0] position_y,
  input  logic signed [31:0] angle_deg,
  input  logic signed [31:0] scale_x,
  input  logic signed [31:0] scale_y,
  output logic               done,
  output logic signed [31:0] m_a,
  output logic signed [31:0] m_b,
  output logic signed [31:0] m_tx,
  output logic signed [31:0] m_c,
  output logic signed [31:0] m_d,
  output logic signed [31:0] m_ty
);

  acu_pkg::payload_t  pay_in, pay_ang, pay_cor;
  acu_pkg::fold_t     fold_ang;
  logic               v_ang, v_cor;
  logic signed [33:0] z_ang, cos_cor, sin_cor;

  // pipeline never holds off
  assign busy = 1'b0;

  assign pay_in = '{ox: origin_x, oy: origin_y, px: position_x, py: position_y,
                    sx: scale_x, sy: scale_y};

  acu_angle u_angle (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start & ~busy),
    .angle_deg (angle_deg),
    .in_pay    (pay_in),
    .out_valid (v_ang),
    .out_z     (z_ang),
    .out_fold  (fold_ang),
    .out_pay   (pay_ang)
  );

  acu_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cordic (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v_ang),
    .in_z      (z_ang),
    .in_fold   (fold_ang),
    .in_pay    (pay_ang),
    .out_valid (v_cor),
    .out_cos   (cos_cor),
    .out_sin   (sin_cor),
    .out_pay   (pay_cor)
  );

  acu_matrix u_matrix (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v_cor),
    .in_cos    (cos_cor),
    .in_sin    (sin_cor),
    .in_pay    (pay_cor),
    .out_valid (done),
    .m_a       (m_a),
    .m_b       (m_b),
    .m_tx      (m_tx),
    .m_c       (m_c),
    .m_d       (m_d),
    .m_ty      (m_ty)
  );

endmodule

[rtl/acu_checker.sv]
`timescale 1ns / 1ps
`include "affine_transform_compose_unit_assert.svh"
module acu_checker #(
  parameter int CORDIC_STAGES = acu_pkg::CordicStagesDefault
) (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic signed [31:0] position_x,
  input logic signed [31:0] scale_x,
  input logic signed [31:0] scale_y,
  input logic               done,
  input logic signed [31:0] m_a,
  input logic signed [31:0] m_b,
  input logic signed [31:0] m_tx,
  input logic signed [31:0] m_c,
  input logic signed [31:0] m_d
);

  localparam int Lat = acu_pkg::latency(CORDIC_STAGES);

  // every accepted word yields a result after the fixed latency
  `ACU_ASSERT_IMP(a_start_done, start && !busy, ##Lat done)
  // no result without a word accepted at the matching cycle
  `ACU_ASSERT_IMP(a_done_start, done, $past(start && !busy, Lat))
  // zero scale gives a pure translation
  `ACU_ASSERT_IMP(a_zero_scale, start && !busy && scale_x == 0 && scale_y == 0,
    ##Lat (m_a == 0 && m_b == 0 && m_c == 0 && m_d == 0 && m_tx == $past(position_x, Lat)))

endmodule

bind affine_transform_compose_unit acu_checker #(.CORDIC_STAGES(CORDIC_STAGES)) u_acu_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .position_x (position_x),
  .scale_x    (scale_x),
  .scale_y    (scale_y),
  .done       (done),
  .m_a        (m_a),
  .m_b        (m_b),
  .m_tx       (m_tx),
  .m_c        (m_c),
  .m_d        (m_d)
);

[dv/tb_affine_transform_compose_unit.sv]
`timescale 1ns / 1ps
module tb_affine_transform_compose_unit;

  localparam int Stages = acu_pkg::CordicStagesDefault;
  localparam int Latency = Stages + 12;
  localparam int WatchdogLimit = 2000;
  localparam longint Deg360 = 64'd23592960;
  localparam longint Deg180 = 64'd11796480;
  localparam longint Deg90 = 64'd5898240;
  localparam longint PiQ29L = 64'd1686629713;
  localparam longint KGain = 64'd652032874;

  typedef struct packed {
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [31:0] tx;
    logic signed [31:0] c;
    logic signed [31:0] d;
    logic signed [31:0] ty;
  } matrix_t;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic signed [31:0] origin_x, origin_y, position_x, position_y;
  logic signed [31:0] angle_deg, scale_x, scale_y;
  logic done;
  logic signed [31:0] m_a, m_b, m_tx, m_c, m_d, m_ty;

  matrix_t matrix_queue[$];
  int errors;
  int idle_cycles;
  bit gaps_on;

  affine_transform_compose_unit dut (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Floor shift of a signed value
  function automatic longint floor_shift(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint atan_entry(int i);
    longint tbl[24] = '{843314856, 497837829, 263043836, 133525158, 67021686,
                        33543515, 16775850, 8388437, 4194282, 2097149, 1048575,
                        524287, 262143, 131071, 65535, 32767, 16383, 8191,
                        4095, 2047, 1023, 511, 255, 127};
    return tbl[i];
  endfunction

  function automatic longint scale_trig(longint s, longint t);
    return clamp32(floor_shift(s * t + (64'sd1 << 29), 30));
  endfunction

  function automatic longint round_q16(longint p);
    return floor_shift(p + (64'sd1 << 15), 16);
  endfunction

  // Compute the matrix for one word
  function automatic matrix_t compose_matrix(logic signed [31:0] ox, oy, px, py, ang,
                                             sx, sy);
    longint r, z, x, y, t, cs, sn, a, b, c, d;
    bit neg_both, neg_cos;
    int n;
    matrix_t m;
    r = longint'(ang) % Deg360;
    if (r < 0) r += Deg360;
    neg_both = 0;
    neg_cos = 0;
    if (r >= Deg180) begin
      r -= Deg180;
      neg_both = 1;
    end
    if (r > Deg90) begin
      r = Deg180 - r;
      neg_cos = 1;
    end
    z = (r * PiQ29L + 2949120) / 5898240;
    x = KGain;
    y = 0;
    n = (Stages > 24) ? 24 : Stages;
    for (int i = 0; i < n; i++) begin
      if (z >= 0) begin
        t = x - floor_shift(y, i);
        y = y + floor_shift(x, i);
        z -= atan_entry(i);
      end else begin
        t = x + floor_shift(y, i);
        y = y - floor_shift(x, i);
        z += atan_entry(i);
      end
      x = t;
    end
    if (neg_cos != neg_both) x = -x;
    if (neg_both) y = -y;
    cs = x;
    sn = -y;
    a = scale_trig(sx, cs);
    b = scale_trig(sy, sn);
    c = scale_trig(sx, -sn);
    d = scale_trig(sy, cs);
    m.a = a[31:0];
    m.b = b[31:0];
    m.c = c[31:0];
    m.d = d[31:0];
    t = clamp32(longint'(px) - round_q16(ox * a) - round_q16(oy * b));
    m.tx = t[31:0];
    t = clamp32(longint'(py) - round_q16(ox * c) - round_q16(oy * d));
    m.ty = t[31:0];
    return m;
  endfunction

  // Drive one word, wait for acceptance, predict its result; start stays
  // high afterwards so that words can follow back to back
  task automatic send_word(logic signed [31:0] ox, oy, px, py, ang, sx, sy);
    while (gaps_on && $urandom_range(99) < 15) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    origin_x <= ox;
    origin_y <= oy;
    position_x <= px;
    position_y <= py;
    angle_deg <= ang;
    scale_x <= sx;
    scale_y <= sy;
    @(posedge clk);
    while (busy) @(posedge clk);
    matrix_queue.push_back(compose_matrix(ox, oy, px, py, ang, sx, sy));
    @(negedge clk);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'($signed($urandom_range(262144)) - 131072);
      3: return 32'($signed($urandom_range(8388608)) - 4194304);
      default: return $urandom;
    endcase
  endfunction

  // Check each result against the oldest prediction
  always @(posedge clk) begin
    matrix_t exp_m;
    if (!rst && done) begin
      if (matrix_queue.size() == 0) begin
        $error("result with no word pending");
        errors++;
      end else begin
        exp_m = matrix_queue.pop_front();
        if (m_a !== exp_m.a) begin
          $error("m_a expected %0d got %0d", exp_m.a, m_a); errors++;
        end
        if (m_b !== exp_m.b) begin
          $error("m_b expected %0d got %0d", exp_m.b, m_b); errors++;
        end
        if (m_tx !== exp_m.tx) begin
          $error("m_tx expected %0d got %0d", exp_m.tx, m_tx); errors++;
        end
        if (m_c !== exp_m.c) begin
          $error("m_c expected %0d got %0d", exp_m.c, m_c); errors++;
        end
        if (m_d !== exp_m.d) begin
          $error("m_d expected %0d got %0d", exp_m.d, m_d); errors++;
        end
        if (m_ty !== exp_m.ty) begin
          $error("m_ty expected %0d got %0d", exp_m.ty, m_ty); errors++;
        end
      end
    end
  end

  // Watchdog: count cycles with no word moving either way
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WatchdogLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Extremes of every field and the angle folding corners
  task automatic test_directed();
    logic signed [31:0] angles[12] = '{32'sd0, 32'sd5898240, 32'sd11796480,
      32'sd17694720, 32'sd23592960, -32'sd5898240, -32'sd23592960, 32'sd5898241,
      32'sh7fffffff, 32'sh80000000, 32'sd2949120, -32'sd1};
    foreach (angles[i])
      send_word(32'sd65536, -32'sd131072, 32'sd0, 32'sd1000, angles[i],
                32'sd65536, 32'sd131072);
    send_word(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 0,
              32'sh7fffffff, 32'sh7fffffff);
    send_word(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000,
              32'sd11796480, 32'sh80000000, 32'sh80000000);
    send_word(32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000,
              32'sd2949120, 32'sh7fffffff, 32'sh80000000);
    send_word(0, 0, 0, 0, 0, 0, 0);
    send_word(-1, -1, -1, -1, -1, -1, -1);
  endtask

  // Hold the sender until the pipeline drains
  task automatic test_drain_pause();
    send_word(rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
              rand_word(), rand_word());
    start <= 1'b0;
    while (matrix_queue.size() != 0) @(negedge clk);
    send_word(rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
              rand_word(), rand_word());
  endtask

  // Random words, with gaps or back to back as with_gaps selects
  task automatic test_random(int count, bit with_gaps);
    gaps_on = with_gaps;
    repeat (count)
      send_word(rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
                rand_word(), rand_word());
    gaps_on = 1'b1;
  endtask

  initial begin
    errors = 0;
    gaps_on = 1'b1;
    rst = 1'b1;
    start = 1'b0;
    origin_x = 0; origin_y = 0; position_x = 0; position_y = 0;
    angle_deg = 0; scale_x = 0; scale_y = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_drain_pause();
    test_random(800, 1'b1);
    test_random(250, 1'b0);
    test_random(180, 1'b1);
    start <= 1'b0;
    while (matrix_queue.size() != 0) @(posedge clk);
    repeat (Latency + 4) @(posedge clk);
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule
